// ===== rtl/hitp_pkg.sv =====
// Package for the hex identifier text parser: status codes, length limits
// and the character classification functions used by the parser datapath.
// No dependencies.
`timescale 1ns / 1ps

package hitp_pkg;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_LENGTH = 3'd2;
  localparam logic [2:0] ST_HYPHEN = 3'd3;
  localparam logic [2:0] ST_NONHEX = 3'd4;

  localparam logic [6:0] LEN_PLAIN  = 7'd64;
  localparam logic [6:0] LEN_DASHED = 7'd69;
  localparam logic [6:0] LEN_CAP    = 7'd70;
  localparam logic [6:0] PEND_CAP   = 7'd127;
  localparam logic [6:0] GUESS_POS  = 7'd16;

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  localparam int NUM_WORDS = 4;

  typedef logic [63:0] word_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || is_letter(c);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (is_digit(c)) begin
      v = c[3:0];
    end else if (is_letter(c)) begin
      v = c[3:0] + 4'd9;
    end
    return v & NIBBLE_MASK;
  endfunction

  function automatic logic is_hyph_pos(input logic [6:0] p);
    return (p == 7'd16) || (p == 7'd25) || (p == 7'd34) || (p == 7'd43) || (p == 7'd52);
  endfunction

  function automatic logic [2:0] hyph_below(input logic [6:0] p);
    return 3'(p > 7'd16) + 3'(p > 7'd25) + 3'(p > 7'd34) + 3'(p > 7'd43)
         + 3'(p > 7'd52);
  endfunction

endpackage

// ===== rtl/hex_id_text_parser.sv =====
// Hex identifier text parser top level: trims whitespace, checks layout and
// packs 64 hex digits into four 64-bit words. Depends on hitp_pkg.
// Results are registered and appear in the cycle after the final character is accepted.
// Throughput: one character per cycle; an ok string emits four results, one per cycle while out_ready is high.
// A final character waits while earlier results are unsent, unless the last leaves that cycle.
// Reset (synchronous, rst_n low) clears the per-string state and empties the result buffer.
`timescale 1ns / 1ps

module hex_id_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_char,
  input  logic        in_has_char,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [63:0] out_id_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_result
);

  hitp_pkg::word_t store_r   [hitp_pkg::NUM_WORDS];
  hitp_pkg::word_t store_nxt [hitp_pkg::NUM_WORDS];
  hitp_pkg::word_t obuf_r    [hitp_pkg::NUM_WORDS];

  logic [6:0] len_r, len_nxt;
  logic [6:0] pend_r, pend_nxt;
  logic       started_r, started_nxt;
  logic       guess_r, guess_nxt;
  logic [2:0] perr_r, perr_nxt;
  logic [2:0] derr_r, derr_nxt;
  logic [3:0] nib_r, nib_nxt;

  logic [2:0] cnt_r;
  logic [1:0] idx_r;
  logic [2:0] status_r;

  logic       in_acc;
  logic       out_pop;
  logic [2:0] fin_status;

  assign in_acc  = in_valid && in_ready;
  assign out_pop = out_valid && out_ready;
  assign in_ready = (cnt_r == 3'd0) || !in_end_of_text || ((cnt_r == 3'd1) && out_ready);

  assign out_valid       = (cnt_r != 3'd0);
  assign out_status      = status_r;
  assign out_id_word     = obuf_r[0];
  assign out_word_index  = idx_r;
  assign out_last_result = (cnt_r == 3'd1);

  always_comb begin
    logic [7:0] sum;
    logic [6:0] p;
    logic [6:0] d;
    logic       hx;
    logic       dash;
    logic       hp;
    logic       do_store;
    len_nxt     = len_r;
    pend_nxt    = pend_r;
    started_nxt = started_r;
    guess_nxt   = guess_r;
    perr_nxt    = perr_r;
    derr_nxt    = derr_r;
    nib_nxt     = nib_r;
    fin_status  = hitp_pkg::ST_OK;
    sum         = 8'd0;
    p           = 7'd0;
    d           = 7'd0;
    hx          = 1'b0;
    dash        = 1'b0;
    hp          = 1'b0;
    do_store    = 1'b0;
    for (int i = 0; i < hitp_pkg::NUM_WORDS; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (in_acc && in_has_char) begin
      if (hitp_pkg::is_space(in_text_char)) begin
        if (started_r && (pend_r < hitp_pkg::PEND_CAP)) begin
          pend_nxt = pend_r + 7'd1;
        end
      end else begin
        started_nxt = 1'b1;
        if (pend_r != 7'd0) begin
          if (perr_nxt == hitp_pkg::ST_OK) begin
            perr_nxt = hitp_pkg::ST_NONHEX;
          end
          if (derr_nxt == hitp_pkg::ST_OK) begin
            derr_nxt = hitp_pkg::is_hyph_pos(len_r) ? hitp_pkg::ST_HYPHEN
                                                    : hitp_pkg::ST_NONHEX;
          end
          sum = {1'b0, len_r} + {1'b0, pend_r};
          if ((len_r <= hitp_pkg::GUESS_POS) && (sum > {1'b0, hitp_pkg::GUESS_POS})) begin
            guess_nxt = 1'b0;
          end
          len_nxt  = (sum > {1'b0, hitp_pkg::LEN_CAP}) ? hitp_pkg::LEN_CAP : sum[6:0];
          pend_nxt = 7'd0;
        end
        p    = len_nxt;
        hx   = hitp_pkg::is_hex(in_text_char);
        dash = (in_text_char == hitp_pkg::CHAR_DASH);
        hp   = hitp_pkg::is_hyph_pos(p);
        if (!hx && (perr_nxt == hitp_pkg::ST_OK)) begin
          perr_nxt = hitp_pkg::ST_NONHEX;
        end
        if (derr_nxt == hitp_pkg::ST_OK) begin
          if (hp) begin
            if (!dash) begin
              derr_nxt = hitp_pkg::ST_HYPHEN;
            end
          end else if (!hx) begin
            derr_nxt = hitp_pkg::ST_NONHEX;
          end
        end
        if (p == hitp_pkg::GUESS_POS) begin
          guess_nxt = dash;
        end
        if (hx) begin
          if (!guess_nxt) begin
            d        = p;
            do_store = 1'b1;
          end else if (!hp) begin
            d        = p - {4'd0, hitp_pkg::hyph_below(p)};
            do_store = 1'b1;
          end
        end
        if (do_store && (d < hitp_pkg::LEN_PLAIN)) begin
          if (!d[0]) begin
            nib_nxt = hitp_pkg::hex_val(in_text_char);
          end else begin
            store_nxt[d[5:4]][{~d[3:1], 3'b000} +: 8] =
              {nib_r & hitp_pkg::NIBBLE_MASK, hitp_pkg::hex_val(in_text_char)};
          end
        end
        len_nxt = (p < hitp_pkg::LEN_CAP) ? p + 7'd1 : hitp_pkg::LEN_CAP;
      end
    end
    if (in_acc && in_end_of_text) begin
      if (len_nxt == 7'd0) begin
        fin_status = hitp_pkg::ST_EMPTY;
      end else if (len_nxt == hitp_pkg::LEN_PLAIN) begin
        fin_status = perr_nxt;
      end else if (len_nxt == hitp_pkg::LEN_DASHED) begin
        fin_status = derr_nxt;
      end else begin
        fin_status = hitp_pkg::ST_LENGTH;
      end
      len_nxt     = 7'd0;
      pend_nxt    = 7'd0;
      started_nxt = 1'b0;
      guess_nxt   = 1'b0;
      perr_nxt    = hitp_pkg::ST_OK;
      derr_nxt    = hitp_pkg::ST_OK;
      nib_nxt     = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < hitp_pkg::NUM_WORDS; i++) begin
      store_r[i] <= store_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= 7'd0;
      pend_r    <= 7'd0;
      started_r <= 1'b0;
      guess_r   <= 1'b0;
      perr_r    <= hitp_pkg::ST_OK;
      derr_r    <= hitp_pkg::ST_OK;
      nib_r     <= 4'd0;
    end else begin
      len_r     <= len_nxt;
      pend_r    <= pend_nxt;
      started_r <= started_nxt;
      guess_r   <= guess_nxt;
      perr_r    <= perr_nxt;
      derr_r    <= derr_nxt;
      nib_r     <= nib_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (in_acc && in_end_of_text) begin
      cnt_r <= (fin_status == hitp_pkg::ST_OK) ? 3'd4 : 3'd1;
      idx_r <= 2'd0;
    end else if (out_pop) begin
      cnt_r <= cnt_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_end_of_text) begin
      status_r <= fin_status;
      for (int i = 0; i < hitp_pkg::NUM_WORDS; i++) begin
        obuf_r[i] <= (fin_status == hitp_pkg::ST_OK) ? store_nxt[i] : 64'd0;
      end
    end else if (out_pop) begin
      for (int i = 0; i < hitp_pkg::NUM_WORDS - 1; i++) begin
        obuf_r[i] <= obuf_r[i + 1];
      end
      obuf_r[hitp_pkg::NUM_WORDS - 1] <= 64'd0;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("Result count exceeds four.");

  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_text) |-> (cnt_r == 3'd0 || (cnt_r == 3'd1 && out_ready)))
    else $error("Final character accepted while earlier results are pending.");

  a_error_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != hitp_pkg::ST_OK) |->
      (out_id_word == 64'd0 && out_word_index == 2'd0 && out_last_result))
    else $error("Error result is not a single zeroed transaction.");

  a_last_word : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == hitp_pkg::ST_OK) |->
      (out_last_result == (out_word_index == 2'd3)))
    else $error("Last result flag does not match word index.");
`endif

endmodule
